// ===== rtl/h264_nal_pkg.sv =====
// Package for the NAL encapsulator: word types, header constants and header byte lookup.
`timescale 1ns / 1ps

package h264_nal_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       idr_frame;
    logic       frame_close;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_last;
  } out_word_t;

  localparam int unsigned ParamSetLen = 24;
  localparam int unsigned HdrLen      = 32;
  localparam int unsigned HdrIdxW     = $clog2(HdrLen);

  localparam logic [HdrIdxW-1:0] IdrFirstIdx = HdrIdxW'(0);
  localparam logic [HdrIdxW-1:0] SliceFirstIdx = HdrIdxW'(ParamSetLen);
  localparam logic [HdrIdxW-1:0] HdrLastIdx = HdrIdxW'(HdrLen - 1);

  localparam logic [31:0] IdrSliceHeader = 32'h25b8_04ff;
  localparam logic [31:0] PSliceHeader   = 32'h21e0_03ff;
  localparam int unsigned FrameShift     = 13;

  localparam logic [7:0] EscByte = 8'h03;

  localparam logic [7:0] ParamSets [ParamSetLen] = '{
    8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h64, 8'h00, 8'h20,
    8'hac, 8'h2b, 8'h40, 8'h6c, 8'h1e, 8'hf3, 8'h68,
    8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hee, 8'h06, 8'h0c, 8'he8
  };

  // Byte at position idx of the header burst; positions below the slice start
  // code hold the SPS and PPS.
  function automatic logic [7:0] hdr_byte(input logic [HdrIdxW-1:0] idx,
                                          input logic idr,
                                          input logic [7:0] frame_num);
    logic [31:0] slice;
    logic [7:0]  b;
    slice = idr ? IdrSliceHeader
                : (PSliceHeader | ({24'd0, frame_num} << FrameShift));
    case (idx) inside
      [HdrIdxW'(24):HdrIdxW'(26)]: b = 8'h00;
      HdrIdxW'(27): b = 8'h01;
      HdrIdxW'(28): b = slice[31:24];
      HdrIdxW'(29): b = slice[23:16];
      HdrIdxW'(30): b = slice[15:8];
      HdrIdxW'(31): b = slice[7:0];
      default: b = ParamSets[idx];
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/h264_nal_encapsulator.sv =====
// Top level: H.264 Annex B NAL encapsulator with emulation prevention.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | in_data_i  (in_word_t)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (out_word_t)
//
// One output word leaves per cycle unless the output stalls or no word is held.
// A payload word emits one byte, or two when an escape byte goes ahead of it; a
// frame start adds 8 (P frame) or 32 (IDR frame) header bytes from the constant
// header lookup. The next input word is taken in the cycle that the current one
// emits its last byte, so unstalled, unescaped payload streams one word per cycle.
// Reset clears the frame counter, the zero-run count and both valid flags.
// A stall on the output holds the output register and, through it, the input.
`timescale 1ns / 1ps

module h264_nal_encapsulator (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  h264_nal_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output h264_nal_pkg::out_word_t out_data_o
);
  import h264_nal_pkg::*;

  typedef enum logic {
    PH_HDR,
    PH_DATA
  } phase_e;

  in_word_t            item_q;
  logic                busy_q;
  phase_e              phase_q;
  logic [HdrIdxW-1:0]  idx_q;
  logic [1:0]          zero_run_q;
  logic [7:0]          frame_num_q;
  out_word_t           out_q;
  logic                out_valid_q;

  logic       emit;
  logic       esc;
  logic       done;
  logic       accept;
  logic [7:0] byte_d;

  assign emit = busy_q && (!out_valid_q || !out_stall_i);
  assign esc  = (phase_q == PH_DATA) && (zero_run_q == 2'd2) && (item_q.data_byte <= 8'd3);
  assign done = emit && (phase_q == PH_DATA) && !esc;
  assign in_stall_o = busy_q && !done;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    if (phase_q == PH_HDR) begin
      byte_d = hdr_byte(idx_q, item_q.idr_frame, frame_num_q);
    end else if (esc) begin
      byte_d = EscByte;
    end else begin
      byte_d = item_q.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= PH_DATA;
      idx_q       <= '0;
      zero_run_q  <= '0;
      frame_num_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (emit) begin
        if (phase_q == PH_HDR) begin
          idx_q <= idx_q + HdrIdxW'(1);
          if (idx_q == HdrLastIdx) begin
            // The header ends in 0xff, so the zero run starts over.
            phase_q     <= PH_DATA;
            zero_run_q  <= '0;
            frame_num_q <= frame_num_q + 8'd1;
          end
        end else if (esc) begin
          zero_run_q <= '0;
        end else if (item_q.data_byte == 8'd0) begin
          if (zero_run_q != 2'd2) begin
            zero_run_q <= zero_run_q + 2'd1;
          end
        end else begin
          zero_run_q <= '0;
        end
      end

      if (done || accept) begin
        busy_q <= accept;
      end
      if (accept) begin
        phase_q <= in_data_i.frame_start ? PH_HDR : PH_DATA;
        idx_q   <= in_data_i.idr_frame ? IdrFirstIdx : SliceFirstIdx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      out_q.out_byte   <= byte_d;
      out_q.run_last   <= done;
      out_q.frame_last <= done && item_q.frame_close;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hdr_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HDR |-> busy_q)
    else $error("header phase without a held word");

  a_zero_run_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q != 2'd3)
    else $error("zero run count out of range");

  a_esc_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && esc |=> busy_q && phase_q == PH_DATA && zero_run_q == 2'd0)
    else $error("escape byte not followed by its payload byte");

  a_hdr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && phase_q == PH_HDR && idx_q == HdrLastIdx
      |=> phase_q == PH_DATA && zero_run_q == 2'd0 && busy_q)
    else $error("header end did not move to payload");

  a_stall_until_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done |-> in_stall_o)
    else $error("input taken before current word finished");

endmodule
